// ----- hdl/hue_pkg.sv -----
// Package for the HTML/URL escape encoder: word types, escape codes, entity text.
// No dependencies; imported by the encoder top level, its checker and the testbench.
`timescale 1ns / 1ps

package hue_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } hue_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } hue_out_t;

  typedef enum logic [2:0] {
    CodePass,
    CodeAmp,
    CodeQuot,
    CodeApos,
    CodeLt,
    CodeGt,
    CodePct
  } hue_code_e;

  localparam logic ModeHtml = 1'b0;
  localparam logic ModeUrl  = 1'b1;

  localparam int unsigned RunMax = 6;
  localparam int unsigned IdxW   = 3;

  // Entity text, left aligned in six byte slots.
  localparam logic [47:0] EntAmp  = {"&amp;", 8'h00};
  localparam logic [47:0] EntQuot = "&quot;";
  localparam logic [47:0] EntApos = "&apos;";
  localparam logic [47:0] EntLt   = {"&lt;", 16'h0000};
  localparam logic [47:0] EntGt   = {"&gt;", 16'h0000};

  localparam logic [7:0] ChPercent = 8'h25;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h37 + {4'h0, nib};
    end
    return r;
  endfunction

endpackage

// ----- hdl/html_url_escape_encoder_unit.sv -----
// HTML entity / URL percent escape encoder, top level.
// Depends on hue_pkg.
//
//   channel  | direction | handshake                 | word
//   ---------+-----------+---------------------------+---------------------------------
//   in       | input     | in_valid_i / in_stall_o   | in_byte, string_end
//   out      | output    | out_valid_o / out_stall_i | out_byte, run_last, string_done
//   cfg      | input     | cfg_valid_i / cfg_ready_o | encode_mode
//
// Three register stages: input capture, classify, run serializer. Without an output
// stall the serializer emits one word per cycle, so an input byte occupies it for its
// run of 1 to 6 words; plain bytes stream at one per cycle. Reset selects HTML mode
// and empties the pipe. A stall on the output holds the serializer and backs up stage
// by stage to in_stall_o.
`timescale 1ns / 1ps

module html_url_escape_encoder_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_encode_mode_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  hue_pkg::hue_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output hue_pkg::hue_out_t out_data_o
);
  import hue_pkg::*;

  logic mode_q;

  // stage 1: captured input
  logic    s1_valid_q;
  hue_in_t s1_data_q;

  // stage 2: classified byte
  logic       s2_valid_q;
  hue_in_t    s2_data_q;
  hue_code_e  s2_code_q;
  hue_code_e  s2_code_d;

  // stage 3: run serializer
  logic            s3_valid_q;
  logic [7:0]      s3_seq_q [RunMax];
  logic [7:0]      s3_seq_d [RunMax];
  logic [IdxW-1:0] s3_last_q;
  logic [IdxW-1:0] s3_last_d;
  logic [IdxW-1:0] s3_idx_q;
  logic            s3_end_q;

  logic out_fire;
  logic s3_at_last;
  logic s3_free;
  logic s2_en;
  logic s1_en;
  logic [47:0] ent;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeHtml;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_encode_mode_i;
    end
  end

  assign s3_at_last = (s3_idx_q == s3_last_q);
  assign out_fire   = s3_valid_q && !out_stall_i;
  assign s3_free    = !s3_valid_q || (out_fire && s3_at_last);
  assign s2_en      = !s2_valid_q || s3_free;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;

  // classify
  always_comb begin
    s2_code_d = CodePass;
    if (mode_q == ModeHtml) begin
      case (s1_data_q.in_byte)
        8'h26:   s2_code_d = CodeAmp;
        8'h22:   s2_code_d = CodeQuot;
        8'h27:   s2_code_d = CodeApos;
        8'h3C:   s2_code_d = CodeLt;
        8'h3E:   s2_code_d = CodeGt;
        default: s2_code_d = CodePass;
      endcase
    end else begin
      // % sp @ = : ; # $ < ? & , > / " + '
      if (s1_data_q.in_byte inside {8'h25, 8'h20, 8'h40, 8'h3D, 8'h3A, 8'h3B,
                                    8'h23, 8'h24, 8'h3C, 8'h3F, 8'h26, 8'h2C,
                                    8'h3E, 8'h2F, 8'h22, 8'h2B, 8'h27}) begin
        s2_code_d = CodePct;
      end
    end
  end

  // build the run
  always_comb begin
    ent       = {s2_data_q.in_byte, 40'h0};
    s3_last_d = IdxW'(0);
    case (s2_code_q)
      CodeAmp: begin
        ent = EntAmp;
        s3_last_d = IdxW'(4);
      end
      CodeQuot: begin
        ent = EntQuot;
        s3_last_d = IdxW'(5);
      end
      CodeApos: begin
        ent = EntApos;
        s3_last_d = IdxW'(5);
      end
      CodeLt: begin
        ent = EntLt;
        s3_last_d = IdxW'(3);
      end
      CodeGt: begin
        ent = EntGt;
        s3_last_d = IdxW'(3);
      end
      CodePct: begin
        ent = {ChPercent, hex_char(s2_data_q.in_byte[7:4]),
               hex_char(s2_data_q.in_byte[3:0]), 24'h0};
        s3_last_d = IdxW'(2);
      end
      default: begin
        ent = {s2_data_q.in_byte, 40'h0};
        s3_last_d = IdxW'(0);
      end
    endcase
    for (int k = 0; k < RunMax; k++) begin
      s3_seq_d[k] = ent[(RunMax-1-k)*8 +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s3_idx_q   <= '0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_free) begin
        s3_valid_q <= s2_valid_q;
        s3_idx_q   <= '0;
      end else if (out_fire) begin
        s3_idx_q <= s3_idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_data_q <= in_data_i;
    end
    if (s2_en) begin
      s2_data_q <= s1_data_q;
      s2_code_q <= s2_code_d;
    end
    if (s3_free) begin
      s3_seq_q  <= s3_seq_d;
      s3_last_q <= s3_last_d;
      s3_end_q  <= s2_data_q.string_end;
    end
  end

  assign out_valid_o             = s3_valid_q;
  assign out_data_o.out_byte     = s3_seq_q[s3_idx_q];
  assign out_data_o.run_last     = s3_at_last;
  assign out_data_o.string_done  = s3_at_last && s3_end_q;

endmodule

// ----- hdl/hue_checker.sv -----
// Port-level checker for the escape encoder, bound to the top level.
// Depends on hue_pkg and html_url_escape_encoder_unit.
`timescale 1ns / 1ps

module hue_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input hue_pkg::hue_out_t out_data_o
);
  import hue_pkg::*;

  // stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.string_done |-> out_data_o.run_last)
    else $error("string_done without run_last");

  // a run, once started, continues without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.run_last |=> out_valid_o)
    else $error("gap inside an escape run");

  // an empty serializer never pushes back on the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output side empty");

endmodule

bind html_url_escape_encoder_unit hue_checker u_hue_checker (.*);

// ----- bench/tb.sv -----
// Testbench for html_url_escape_encoder_unit: HTML entity and URL percent escaping.
// Depends on hue_pkg and the encoder RTL; a directed table is followed by random
// bursts in both modes, each word checked against typed table text or a predictor.
`timescale 1ns / 1ps

module tb;
  import hue_pkg::*;

  // Directed table row. A typed row carries its expected run text (left aligned).
  typedef struct packed {
    logic        mode;
    logic [7:0]  ch;
    logic        last;
    logic        typed;
    logic [2:0]  len;
    logic [47:0] txt;
  } plan_row_t;

  localparam int unsigned PlanLen = 26;
  localparam int unsigned Phases  = 6;
  localparam int unsigned PerPhase = 32;

  // The seventeen characters that URL mode escapes.
  localparam logic [8*17-1:0] UrlSet = "%@=:;#$<?&,>/\"+' ";
  localparam logic [8*16-1:0] HexDigits = "0123456789ABCDEF";

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic     cfg_encode_mode_i = ModeHtml;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  hue_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  hue_out_t out_data_o;

  hue_out_t  escaped_q[$];
  hue_out_t  exp_w;
  logic      cur_mode = ModeHtml;
  logic      src_quiet = 1'b0;
  logic      sink_quiet = 1'b0;
  int        stall_hold = 0;
  int        errors = 0;
  int        words_seen = 0;
  int        bytes_sent = 0;
  int        mode_writes = 0;

  plan_row_t plan [PlanLen] = '{
    '{ModeHtml, 8'h00, 1'b0, 1'b1, 3'd1, {8'h00, 40'h0}},
    '{ModeHtml, 8'hFF, 1'b1, 1'b1, 3'd1, {8'hFF, 40'h0}},
    '{ModeHtml, "&",   1'b0, 1'b1, 3'd5, {"&amp;", 8'h00}},
    '{ModeHtml, "\"",  1'b0, 1'b1, 3'd6, "&quot;"},
    '{ModeHtml, "'",   1'b1, 1'b1, 3'd6, "&apos;"},
    '{ModeHtml, "<",   1'b0, 1'b1, 3'd4, {"&lt;", 16'h0}},
    '{ModeHtml, ">",   1'b0, 1'b1, 3'd4, {"&gt;", 16'h0}},
    '{ModeHtml, 8'h7F, 1'b1, 1'b0, 3'd0, 48'h0},
    '{ModeUrl,  "%",   1'b0, 1'b1, 3'd3, {"%25", 24'h0}},
    '{ModeUrl,  " ",   1'b0, 1'b1, 3'd3, {"%20", 24'h0}},
    '{ModeUrl,  "@",   1'b0, 1'b1, 3'd3, {"%40", 24'h0}},
    '{ModeUrl,  "=",   1'b0, 1'b1, 3'd3, {"%3D", 24'h0}},
    '{ModeUrl,  ":",   1'b0, 1'b0, 3'd0, 48'h0},
    '{ModeUrl,  ";",   1'b0, 1'b0, 3'd0, 48'h0},
    '{ModeUrl,  "#",   1'b0, 1'b0, 3'd0, 48'h0},
    '{ModeUrl,  "$",   1'b1, 1'b0, 3'd0, 48'h0},
    '{ModeUrl,  "<",   1'b0, 1'b0, 3'd0, 48'h0},
    '{ModeUrl,  "?",   1'b0, 1'b0, 3'd0, 48'h0},
    '{ModeUrl,  "&",   1'b0, 1'b0, 3'd0, 48'h0},
    '{ModeUrl,  ",",   1'b0, 1'b0, 3'd0, 48'h0},
    '{ModeUrl,  ">",   1'b0, 1'b0, 3'd0, 48'h0},
    '{ModeUrl,  "/",   1'b0, 1'b1, 3'd3, {"%2F", 24'h0}},
    '{ModeUrl,  "\"",  1'b0, 1'b0, 3'd0, 48'h0},
    '{ModeUrl,  "+",   1'b0, 1'b1, 3'd3, {"%2B", 24'h0}},
    '{ModeUrl,  "'",   1'b1, 1'b1, 3'd3, {"%27", 24'h0}},
    '{ModeUrl,  8'h80, 1'b1, 1'b0, 3'd0, 48'h0}
  };

  html_url_escape_encoder_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_encode_mode_i(cfg_encode_mode_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_o       (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Timeout at %0t, %0d words still pending", $time, escaped_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bit url_listed(input logic [7:0] b);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < 17; i++) begin
      if (UrlSet[8*i +: 8] == b) hit = 1'b1;
    end
    return hit;
  endfunction

  // Queue the expected run for one text byte under the given mode.
  function automatic void predict_escape(input logic [7:0] b, input logic eos, input logic m);
    logic [47:0] run;
    int          n;
    hue_out_t    w;
    run = {b, 40'h0};
    n = 1;
    if (m == ModeHtml) begin
      case (b)
        "&":  begin run = {"&amp;", 8'h00}; n = 5; end
        "\"": begin run = "&quot;"; n = 6; end
        "'":  begin run = "&apos;"; n = 6; end
        "<":  begin run = {"&lt;", 16'h0}; n = 4; end
        ">":  begin run = {"&gt;", 16'h0}; n = 4; end
        default: ;
      endcase
    end else if (url_listed(b)) begin
      run = {8'h25, HexDigits[8*(15 - b[7:4]) +: 8], HexDigits[8*(15 - b[3:0]) +: 8], 24'h0};
      n = 3;
    end
    for (int k = 0; k < n; k++) begin
      w.out_byte    = run[47 - 8*k -: 8];
      w.run_last    = (k == n - 1);
      w.string_done = (k == n - 1) && eos;
      escaped_q.push_back(w);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (src_quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return UrlSet[8*$urandom_range(0, 16) +: 8];
    if (r < 65) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  // Called at a rising edge; returns at the edge where the word was taken, or after the random gap that follows it.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = pick_gap();
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: b, string_end: eos};
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid_i       <= 1'b1;
    cfg_encode_mode_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_mode = m;
    mode_writes++;
  endtask

  // Output stall: mostly short bursts, now and then a long one.
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (sink_quiet || r < 70) begin
        out_stall_i <= 1'b0;
      end else if (r < 95) begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(0, 3);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold  <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      words_seen++;
      if (escaped_q.size() == 0) begin
        $display("%0t: unexpected word %h/%b/%b", $time, out_data_o.out_byte,
                 out_data_o.run_last, out_data_o.string_done);
        errors++;
      end else begin
        exp_w = escaped_q.pop_front();
        if (out_data_o.out_byte !== exp_w.out_byte || out_data_o.run_last !== exp_w.run_last
            || out_data_o.string_done !== exp_w.string_done) begin
          $display("%0t: mismatch: expected byte %h last %b done %b, got byte %h last %b done %b",
                   $time, exp_w.out_byte, exp_w.run_last, exp_w.string_done,
                   out_data_o.out_byte, out_data_o.run_last, out_data_o.string_done);
          errors++;
        end
      end
    end
  end

  initial begin
    hue_out_t w;
    logic     m;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; a mode change drains the pipe first.
    for (int i = 0; i < PlanLen; i++) begin
      if (plan[i].mode != cur_mode) begin
        drain_pipe();
        write_mode(plan[i].mode);
      end
      if (plan[i].typed) begin
        for (int k = 0; k < plan[i].len; k++) begin
          w.out_byte    = plan[i].txt[47 - 8*k -: 8];
          w.run_last    = (k == plan[i].len - 1);
          w.string_done = (k == plan[i].len - 1) && plan[i].last;
          escaped_q.push_back(w);
        end
      end else begin
        predict_escape(plan[i].ch, plan[i].last, cur_mode);
      end
      send_byte(plan[i].ch, plan[i].last);
    end

    // Random bursts; the first two phases pin both mode values.
    for (int p = 0; p < Phases; p++) begin
      drain_pipe();
      m = (p == 0) ? ModeHtml : (p == 1) ? ModeUrl : logic'($urandom_range(0, 1));
      write_mode(m);
      src_quiet  = (p % 3 == 2);
      sink_quiet = (p % 4 == 3);
      for (int i = 0; i < PerPhase; i++) begin
        logic [7:0] b;
        logic       eos;
        b   = pick_byte();
        eos = ($urandom_range(0, 7) == 0);
        predict_escape(b, eos, cur_mode);
        send_byte(b, eos);
      end
    end

    in_valid_i <= 1'b0;
    sink_quiet = 1'b0;
    while (escaped_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d text bytes over %0d mode writes; %0d escaped words checked.",
             bytes_sent, mode_writes, words_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/hue_pkg.sv
hdl/html_url_escape_encoder_unit.sv
hdl/hue_checker.sv
bench/tb.sv
